[rtl/bdrs_pkg.sv]
// ============================================================================
// bdrs_pkg
// Shared constants, state encoding and controller/datapath bundles for the
// block-decomposed range-sum unit.
// ============================================================================
package bdrs_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_BLOCK_SIZE   = 32;

    localparam int ELEM_W  = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int SUM_W   = 42;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_WR_READ = 6'b000100,
        ST_WR_UPD  = 6'b001000,
        ST_Q_RUN   = 6'b010000,
        ST_Q_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic wr_update;
        logic q_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic write_ok;
        logic query_bad;
        logic q_end;
        logic out_free;
    } status_t;

endpackage

[rtl/block_decomposed_range_sum_unit.sv]
// ============================================================================
// block_decomposed_range_sum_unit
// Range-sum store with per-block sums: element writes and inclusive
// range-sum queries.
// ============================================================================
// After reset the unit clears the element store and the block-sum table
// entry by entry and accepts no beat during that pass (the count
// register can be written). Items are then taken one at a time. A write
// accepts the beat, reads the old value and block sum, then writes back.
// A query walks its range step by step: each step reads one element or one
// whole-block sum through the single read port of each store, so a query
// needs at most 2*(BLOCK_SIZE-1) + MAX_ELEMENTS/BLOCK_SIZE - 2 steps, 92 at
// the default sizes. Error queries skip the walk and go straight to the
// result hand-off. A finished result waits in the output register while
// the next beat is accepted; a query result that finds that register still
// stalled holds the unit until it drains.
module block_decomposed_range_sum_unit
    import bdrs_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic [INDEX_W-1:0]        element_index,
    input  logic signed [ELEM_W-1:0]  element_value,
    input  logic [INDEX_W-1:0]        range_low,
    input  logic [INDEX_W-1:0]        range_high,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [SUM_W-1:0]   range_sum,
    output logic                      range_error,
    input  logic                      cfg_we,
    input  logic [COUNT_W-1:0]        cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    bdrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bdrs_datapath
    #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .BLOCK_SIZE   (BLOCK_SIZE)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .op            (op),
        .element_index (element_index),
        .element_value (element_value),
        .range_low     (range_low),
        .range_high    (range_high),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .range_sum     (range_sum),
        .range_error   (range_error)
    );

endmodule

[rtl/bdrs_ctrl.sv]
// ============================================================================
// bdrs_ctrl
// Sequencer for the range-sum unit: clearing pass, write read-modify-write,
// query walk and result hand-off.
// ============================================================================
module bdrs_ctrl
    import bdrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.is_query)
                    begin
                        state_next = status.query_bad ? ST_Q_DONE : ST_Q_RUN;
                    end
                    else
                    begin
                        state_next = status.write_ok ? ST_WR_READ : ST_IDLE;
                    end
                end
            end
            ST_WR_READ:
            begin
                state_next = ST_WR_UPD;
            end
            ST_WR_UPD:
            begin
                cmd.wr_update = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_Q_RUN:
            begin
                cmd.q_step = 1'b1;
                if (status.q_end)
                begin
                    state_next = ST_Q_DONE;
                end
            end
            ST_Q_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[rtl/bdrs_datapath.sv]
// ============================================================================
// bdrs_datapath
// Element store, block-sum table, walk pointer, accumulator, count register
// and output register of the range-sum unit.
// ============================================================================
module bdrs_datapath
    import bdrs_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic                      op,
    input  logic [INDEX_W-1:0]        element_index,
    input  logic signed [ELEM_W-1:0]  element_value,
    input  logic [INDEX_W-1:0]        range_low,
    input  logic [INDEX_W-1:0]        range_high,
    input  logic                      cfg_we,
    input  logic [COUNT_W-1:0]        cfg_wdata,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [SUM_W-1:0]   range_sum,
    output logic                      range_error
);

    localparam int LBS    = $clog2(BLOCK_SIZE);
    localparam int AW     = $clog2(MAX_ELEMENTS);
    localparam int GROUPS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PW     = $clog2(MAX_ELEMENTS + BLOCK_SIZE + 1);
    localparam int XW     = (PW > COUNT_W) ? PW : COUNT_W;
    localparam int BSW    = ELEM_W + LBS;

    logic [ELEM_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [BSW-1:0]    bsum_mem [GROUPS];

    logic [COUNT_W-1:0]      count_reg;
    logic [AW-1:0]           clr_reg;
    logic [XW-1:0]           p_reg;
    logic [XW-1:0]           hi_reg;
    logic signed [ELEM_W-1:0] val_reg;
    logic                    pend_reg;
    logic                    kind_reg;
    logic [SUM_W-1:0]        acc_reg;
    logic                    err_reg;
    logic                    out_valid_reg;
    logic [SUM_W-1:0]        out_sum_reg;
    logic                    out_err_reg;
    logic [ELEM_W-1:0]       elem_q;
    logic [BSW-1:0]          bsum_q;

    logic [XW-1:0]     lo_x;
    logic [XW-1:0]     hi_x;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     count_x;
    logic [XW-1:0]     count_lim;
    logic [XW-1:0]     p_shift;
    logic [XW-1:0]     clr_shift;
    logic [GW-1:0]     p_grp;
    logic [GW-1:0]     clr_grp;
    logic              whole_block;
    logic              p_past;
    logic              elem_we;
    logic [AW-1:0]     elem_wa;
    logic [ELEM_W-1:0] elem_wd;
    logic [GW-1:0]     bsum_wa;
    logic [BSW-1:0]    bsum_wd;
    logic [BSW-1:0]    bsum_upd;

    assign lo_x      = XW'(range_low);
    assign hi_x      = XW'(range_high);
    assign idx_x     = XW'(element_index);
    assign count_x   = XW'(count_reg);
    assign count_lim = (count_x > XW'(MAX_ELEMENTS)) ? XW'(MAX_ELEMENTS) : count_x;

    assign p_shift   = p_reg >> LBS;
    assign clr_shift = XW'(clr_reg) >> LBS;
    assign p_grp     = p_shift[GW-1:0];
    assign clr_grp   = clr_shift[GW-1:0];

    assign p_past      = p_reg > hi_reg;
    assign whole_block = (p_reg[LBS-1:0] == '0)
                         && ((p_reg + XW'(BLOCK_SIZE - 1)) <= hi_reg);

    assign bsum_upd = bsum_q + BSW'(val_reg) - BSW'($signed(elem_q));

    assign elem_we = cmd.clr_step | cmd.wr_update;
    assign elem_wa = cmd.clr_step ? clr_reg : p_reg[AW-1:0];
    assign elem_wd = cmd.clr_step ? '0 : val_reg;
    assign bsum_wa = cmd.clr_step ? clr_grp : p_grp;
    assign bsum_wd = cmd.clr_step ? '0 : bsum_upd;

    assign status.clr_last  = clr_reg == AW'(MAX_ELEMENTS - 1);
    assign status.is_query  = op == OP_QUERY;
    assign status.write_ok  = idx_x < XW'(MAX_ELEMENTS);
    assign status.query_bad = (lo_x > hi_x) || (hi_x >= count_lim);
    assign status.q_end     = p_past && !pend_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_wa] <= elem_wd;
        end
        elem_q <= elem_mem[p_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            bsum_mem[bsum_wa] <= bsum_wd;
        end
        bsum_q <= bsum_mem[p_grp];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.q_step)
            begin
                pend_reg <= !p_past;
            end
            out_valid_reg <= cmd.out_load | (out_valid_reg & out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg   <= status.is_query ? lo_x : idx_x;
            hi_reg  <= hi_x;
            val_reg <= element_value;
            acc_reg <= '0;
            err_reg <= status.query_bad;
        end
        else if (cmd.q_step)
        begin
            if (!p_past)
            begin
                kind_reg <= whole_block;
                p_reg    <= whole_block ? p_reg + XW'(BLOCK_SIZE) : p_reg + XW'(1);
            end
            if (pend_reg)
            begin
                acc_reg <= acc_reg + (kind_reg ? SUM_W'($signed(bsum_q))
                                               : SUM_W'($signed(elem_q)));
            end
        end
        if (cmd.out_load)
        begin
            out_sum_reg <= acc_reg;
            out_err_reg <= err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign range_sum   = $signed(out_sum_reg);
    assign range_error = out_err_reg;

endmodule

[dv/block_decomposed_range_sum_unit_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// block_decomposed_range_sum_unit_tb
// Drives element writes and range-sum queries through the valid/stall
// channels with random idle and stall bursts. A shadow copy of the element
// store and count register predicts every query result, and each output beat
// is checked field by field against the oldest pending prediction. The count
// register is moved through zero, one, oversized, a random mid value and its
// reset value between phases.
// ============================================================================
module block_decomposed_range_sum_unit_tb
    import bdrs_pkg::*;
();

    localparam int N_ELEM      = DEF_MAX_ELEMENTS;
    localparam int GROUP_LEN   = DEF_BLOCK_SIZE;
    localparam int SETTLE      = 200;
    localparam int CYCLE_LIMIT = 800000;
    localparam int PRINT_CAP   = 50;

    typedef struct {
        logic                     op;
        logic [INDEX_W-1:0]       element_index;
        logic signed [ELEM_W-1:0] element_value;
        logic [INDEX_W-1:0]       range_low;
        logic [INDEX_W-1:0]       range_high;
    } beat_t;

    typedef struct {
        logic signed [SUM_W-1:0] total;
        logic                    bad;
    } range_result_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_stall;
    logic                     op            = OP_WRITE;
    logic [INDEX_W-1:0]       element_index = '0;
    logic signed [ELEM_W-1:0] element_value = '0;
    logic [INDEX_W-1:0]       range_low     = '0;
    logic [INDEX_W-1:0]       range_high    = '0;
    logic                     out_valid;
    logic                     out_stall     = 1'b0;
    logic signed [SUM_W-1:0]  range_sum;
    logic                     range_error;
    logic                     cfg_we        = 1'b0;
    logic [COUNT_W-1:0]       cfg_wdata     = '0;

    beat_t         pending_beats[$];
    range_result_t sums_due[$];

    logic signed [ELEM_W-1:0] store_shadow [N_ELEM];
    logic [COUNT_W-1:0]       count_shadow = COUNT_RESET;

    beat_t         next_beat;
    beat_t         seen_beat;
    range_result_t want;
    logic          in_took  = 1'b0;
    logic          calm     = 1'b0;
    int            in_gap   = 0;
    int            out_gap  = 0;
    int            cycles   = 0;
    int            mismatches = 0;
    int            writes_seen = 0;
    int            queries_seen = 0;
    int            flagged_seen = 0;
    int            settings_used = 0;

    block_decomposed_range_sum_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .element_index (element_index),
        .element_value (element_value),
        .range_low     (range_low),
        .range_high    (range_high),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .range_sum     (range_sum),
        .range_error   (range_error),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int live_count();
        if (count_shadow > N_ELEM)
            return N_ELEM;
        return int'(count_shadow);
    endfunction

    function automatic void apply_beat(beat_t b);
        range_result_t r;
        longint        acc;
        int            lim;
        lim = live_count();
        if (b.op == OP_WRITE)
        begin
            store_shadow[b.element_index] = b.element_value;
            writes_seen++;
        end
        else
        begin
            queries_seen++;
            if (b.range_low > b.range_high || b.range_high >= lim)
            begin
                r.total = '0;
                r.bad   = 1'b1;
                flagged_seen++;
            end
            else
            begin
                acc = 0;
                for (int i = b.range_low; i <= b.range_high; i++)
                    acc += store_shadow[i];
                r.total = acc[SUM_W-1:0];
                r.bad   = 1'b0;
            end
            sums_due.push_back(r);
        end
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycles, what);
    endtask

    function automatic logic [ELEM_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_write(input int idx, input logic [ELEM_W-1:0] val);
        beat_t b;
        b.op            = OP_WRITE;
        b.element_index = INDEX_W'(idx);
        b.element_value = val;
        b.range_low     = INDEX_W'($urandom);
        b.range_high    = INDEX_W'($urandom);
        pending_beats.push_back(b);
    endtask

    task automatic queue_query(input int lo, input int hi);
        beat_t b;
        b.op            = OP_QUERY;
        b.element_index = INDEX_W'($urandom);
        b.element_value = $urandom;
        b.range_low     = INDEX_W'(lo);
        b.range_high    = INDEX_W'(hi);
        pending_beats.push_back(b);
    endtask

    task automatic queue_random(input int n);
        int lim;
        int lo;
        int hi;
        int blk_end;
        int kind;
        lim = live_count();
        repeat (n)
        begin
            if ($urandom_range(0, 1))
            begin
                if (lim > 0 && $urandom_range(0, 1))
                    queue_write($urandom_range(0, lim - 1), pick_value());
                else
                    queue_write($urandom_range(0, N_ELEM - 1), pick_value());
            end
            else
            begin
                kind = $urandom_range(0, 9);
                lo = $urandom_range(0, N_ELEM - 1);
                hi = $urandom_range(0, N_ELEM - 1);
                if (kind == 0 || (kind == 1 && lim >= N_ELEM))
                begin
                    lo = $urandom_range(1, N_ELEM - 1);
                    hi = $urandom_range(0, lo - 1);
                end
                else if (kind == 1)
                begin
                    hi = $urandom_range(lim, N_ELEM - 1);
                    lo = $urandom_range(0, hi);
                end
                else if (kind == 2 && lim > 0)
                begin
                    lo = $urandom_range(0, lim - 1);
                    blk_end = lo | (GROUP_LEN - 1);
                    if (blk_end > lim - 1)
                        blk_end = lim - 1;
                    hi = $urandom_range(lo, blk_end);
                end
                else if (kind > 3 && lim > 0)
                begin
                    lo = $urandom_range(0, lim - 1);
                    hi = $urandom_range(lo, lim - 1);
                end
                queue_query(lo, hi);
            end
        end
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(input logic [COUNT_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        count_shadow = value;
        settings_used++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // input driver: hold while stalled, advance on an accepted beat
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_beats.size() > 0)
            begin
                next_beat = pending_beats.pop_front();
                op            <= next_beat.op;
                element_index <= next_beat.element_index;
                element_value <= next_beat.element_value;
                range_low     <= next_beat.range_low;
                range_high    <= next_beat.range_high;
                in_valid      <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    in_gap <= $urandom_range(1, 11);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap   <= out_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 9) == 0)
                out_gap <= $urandom_range(1, 11);
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                seen_beat.op            = op;
                seen_beat.element_index = element_index;
                seen_beat.element_value = element_value;
                seen_beat.range_low     = range_low;
                seen_beat.range_high    = range_high;
                apply_beat(seen_beat);
            end
            if (out_valid && !out_stall)
            begin
                if (sums_due.size() == 0)
                    flag_mismatch("output beat with no query outstanding");
                else
                begin
                    want = sums_due.pop_front();
                    if (range_sum !== want.total)
                        flag_mismatch($sformatf("range_sum got %0d want %0d",
                                                range_sum, want.total));
                    if (range_error !== want.bad)
                        flag_mismatch($sformatf("range_error got %b want %b",
                                                range_error, want.bad));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, sums_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int mid;
        for (int i = 0; i < N_ELEM; i++)
            store_shadow[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_write(0, 32'h7FFF_FFFF);
        queue_write(N_ELEM - 1, 32'h8000_0000);
        queue_write(31, 32'hFFFF_FFFF);
        queue_write(32, 32'h7FFF_FFFF);
        queue_write(511, 32'h1234_5678);
        queue_write(0, 32'h8000_0000);
        queue_query(0, 0);
        queue_query(N_ELEM - 1, N_ELEM - 1);
        queue_query(0, N_ELEM - 1);
        queue_query(31, 32);
        queue_query(3, 20);
        queue_query(30, 64);
        queue_query(33, N_ELEM - 2);
        queue_query(5, 4);
        queue_query(N_ELEM - 1, 0);
        queue_random(250);

        set_count('0);
        queue_query(0, 0);
        queue_random(40);

        set_count(11'd1);
        queue_query(0, 0);
        queue_query(0, 1);
        queue_random(80);

        set_count(11'h7FF);
        queue_query(0, N_ELEM - 1);
        queue_random(140);

        mid = $urandom_range(2, N_ELEM - 1);
        set_count(COUNT_W'(mid));
        queue_query(0, mid - 1);
        queue_query(0, mid);
        queue_random(140);

        set_count(COUNT_RESET);
        calm = 1'b1;
        queue_random(200);

        drain();
        $display("Covered %0d writes and %0d queries (%0d out of range or reversed)",
                 writes_seen, queries_seen, flagged_seen);
        $display("across %0d count register settings, %0d mismatches",
                 settings_used, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
